// ===== hw/rtl/ue2u_pkg.sv =====
// Shared types, character codes and UTF-8 helpers for the escape converter.
package ue2u_pkg;

   // Escape layout: backslash, mark, four hex digits
   localparam int EscLen     = 6;
   localparam int CountW     = 3;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;

   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharEscMark   = 8'h75;
   localparam logic [7:0] CharZero      = 8'h30;
   localparam logic [7:0] CharNine      = 8'h39;
   localparam logic [7:0] CharLowA      = 8'h61;
   localparam logic [7:0] CharLowF      = 8'h66;
   localparam logic [7:0] CharUpA       = 8'h41;
   localparam logic [7:0] CharUpF       = 8'h46;
   localparam logic [3:0] HexAlphaOffset = 4'd10;

   localparam logic [7:0] Utf8Lead2 = 8'hC0;
   localparam logic [7:0] Utf8Lead3 = 8'hE0;
   localparam logic [7:0] Utf8Cont  = 8'h80;

   localparam logic [1:0] Utf8Len1 = 2'd1;
   localparam logic [1:0] Utf8Len2 = 2'd2;
   localparam logic [1:0] Utf8Len3 = 2'd3;

   // One classified stream byte
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_bs;
      logic       is_mark;
      logic       is_hex;
      logic [3:0] nibble;
   } item_type;

   // Tag a byte with its role in an escape and its hex value
   function automatic item_type classify(input logic [7:0] b, input logic last);
      item_type   it;
      logic [7:0] d;
      it.data    = b;
      it.last    = last;
      it.is_bs   = (b == CharBackslash);
      it.is_mark = (b == CharEscMark);
      it.is_hex  = 1'b0;
      it.nibble  = 4'd0;
      d          = 8'd0;
      if (b inside {[CharZero:CharNine]}) begin
         d         = b - CharZero;
         it.is_hex = 1'b1;
         it.nibble = d[3:0];
      end else if (b inside {[CharLowA:CharLowF]}) begin
         d         = b - CharLowA;
         it.is_hex = 1'b1;
         it.nibble = d[3:0] + HexAlphaOffset;
      end else if (b inside {[CharUpA:CharUpF]}) begin
         d         = b - CharUpA;
         it.is_hex = 1'b1;
         it.nibble = d[3:0] + HexAlphaOffset;
      end
      return it;
   endfunction

   // Number of UTF-8 bytes for a 16-bit code point
   function automatic logic [1:0] utf8_len(input logic [15:0] cp);
      logic [1:0] len;
      if (cp[15:7] == 9'd0) begin
         len = Utf8Len1;
      end else if (cp[15:11] == 5'd0) begin
         len = Utf8Len2;
      end else begin
         len = Utf8Len3;
      end
      return len;
   endfunction

   // UTF-8 byte number idx of a 16-bit code point
   function automatic logic [7:0] utf8_byte(input logic [15:0] cp, input logic [1:0] idx);
      logic [7:0] b;
      case (utf8_len(cp))
         Utf8Len1: begin
            b = {1'b0, cp[6:0]};
         end
         Utf8Len2: begin
            if (idx == 2'd0) begin
               b = Utf8Lead2 | {3'b000, cp[10:6]};
            end else begin
               b = Utf8Cont | {2'b00, cp[5:0]};
            end
         end
         default: begin
            case (idx)
               2'd0:    b = Utf8Lead3 | {4'b0000, cp[15:12]};
               2'd1:    b = Utf8Cont | {2'b00, cp[11:6]};
               default: b = Utf8Cont | {2'b00, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/ue2u_front.sv =====
// Input stage: accepts stream bytes, classifies them and hands them to the queue.
module ue2u_front import ue2u_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       push_valid,
   output item_type   push_item,
   input  logic       push_ready
);

   logic     fr_valid_ff, fr_valid_in;
   item_type fr_item_ff, fr_item_in;
   logic     accept;

   // Take a new item whenever the stage is empty or draining this cycle
   assign req_tready = !fr_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = fr_valid_ff;
   assign push_item  = fr_item_ff;

   // Hold or replace the staged item
   always_comb begin
      fr_valid_in = (fr_valid_ff && !push_ready) || accept;
      fr_item_in  = fr_item_ff;
      if (accept) begin
         fr_item_in = classify(req_tdata, req_tlast);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_item_ff <= fr_item_in;
   end

endmodule

// ===== hw/rtl/ue2u_queue.sv =====
// Short queue of classified items between the input stage and the escape engine.
module ue2u_queue import ue2u_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   item_type               slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign push_ready = (fill_ff != (QueuePtrW+1)'(QueueDepth));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/ue2u_back.sv =====
// Escape engine: holds a forming escape, emits plain or UTF-8 bytes one per cycle while the output is not stalled.
module ue2u_back import ue2u_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  item_type   pop_item,
   output logic       pop_ready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   item_type          held_ff [EscLen];
   item_type          held_in [EscLen];
   logic [CountW-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              step_last_ff, step_last_in;
   logic [1:0]        esc_idx_ff, esc_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              slot_free;
   logic              prefix;
   logic [15:0]       cp;
   logic [1:0]        esc_len;
   logic [7:0]        esc_byte;
   logic              emit;
   logic [7:0]        emit_data;
   logic              emit_last;
   logic              drop;
   logic              pop_ok;
   logic [CountW-1:0] cnt_after;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cp        = {held_ff[2].nibble, held_ff[3].nibble,
                       held_ff[4].nibble, held_ff[5].nibble};
   assign esc_len   = utf8_len(cp);
   assign esc_byte  = utf8_byte(cp, esc_idx_ff);

   // Check that the held bytes still start an escape
   always_comb begin
      prefix = 1'b1;
      for (int i = 0; i < EscLen; i++) begin
         if (CountW'(i) < count_ff) begin
            if (i == 0) begin
               if (!held_ff[i].is_bs) prefix = 1'b0;
            end else if (i == 1) begin
               if (!held_ff[i].is_mark) prefix = 1'b0;
            end else begin
               if (!held_ff[i].is_hex) prefix = 1'b0;
            end
         end
      end
   end

   // Pick this cycle's action, then append a new item where room opens up
   always_comb begin
      emit         = 1'b0;
      emit_data    = held_ff[0].data;
      emit_last    = 1'b0;
      drop         = 1'b0;
      pop_ok       = 1'b0;
      cnt_after    = count_ff;
      busy_in      = busy_ff;
      esc_idx_in   = esc_idx_ff;
      step_last_in = step_last_ff;

      if (!busy_ff) begin
         pop_ok = 1'b1;
      end else if (prefix && (count_ff == CountW'(EscLen))) begin
         // Emit the encoded code point
         if (slot_free) begin
            emit      = 1'b1;
            emit_data = esc_byte;
            if (esc_idx_ff == 2'(esc_len - 2'd1)) begin
               cnt_after  = '0;
               emit_last  = step_last_ff;
               esc_idx_in = 2'd0;
            end else begin
               esc_idx_in = esc_idx_ff + 2'd1;
            end
         end
      end else if (!prefix || step_last_ff) begin
         // Emit the first held byte as plain text and drop it
         if (slot_free) begin
            emit      = 1'b1;
            drop      = 1'b1;
            cnt_after = count_ff - 1'b1;
            emit_last = step_last_ff && (count_ff == CountW'(1));
         end
      end else begin
         // Escape still forming: wait for more bytes
         busy_in = 1'b0;
         pop_ok  = 1'b1;
      end

      if (emit && (cnt_after == '0)) begin
         busy_in = 1'b0;
         pop_ok  = 1'b1;
      end

      for (int i = 0; i < EscLen; i++) begin
         held_in[i] = held_ff[i];
      end
      if (drop) begin
         for (int i = 0; i < EscLen - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
      end

      count_in = cnt_after;
      if (pop_ok && pop_valid) begin
         for (int i = 0; i < EscLen; i++) begin
            if (CountW'(i) == cnt_after) begin
               held_in[i] = pop_item;
            end
         end
         count_in     = cnt_after + 1'b1;
         busy_in      = 1'b1;
         step_last_in = pop_item.last;
      end
   end

   assign pop_ready = pop_ok;

   // Load the output register or hold it while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (slot_free) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_data_in = emit_data;
            rsp_last_in = emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         esc_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         esc_idx_ff   <= esc_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < EscLen; i++) begin
         held_ff[i] <= held_in[i];
      end
      step_last_ff <= step_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/unicode_escape_to_utf8_core.sv =====
// Top level of the unicode escape to UTF-8 stream converter.
// Replaces every six-byte escape (backslash, 'u', four hex digits) in the byte
// stream with the code point in UTF-8 (one to three bytes, surrogates in plain
// three-byte form); all other bytes pass unchanged, and bytes held at a tlast
// byte are flushed as plain text, with rsp_tlast on that byte's final output.
// The escape engine emits at most one output byte per cycle, so plain text
// flows at one byte per cycle while the receiver does not stall; a byte that
// breaks a held escape releases the held bytes one at a time, and a completed
// escape sends its UTF-8 bytes one at a time, with no new byte taken meanwhile.
// An input register and a four-entry queue before the engine absorb these
// stalls; a byte passes the input register, queue, held escape and the
// output register in turn. The block resumes after reset with no sweep.
module unicode_escape_to_utf8_core import ue2u_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   ue2u_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   ue2u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   ue2u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sim/unicode_escape_to_utf8_core_test.sv =====
// Self-checking testbench for the unicode escape to UTF-8 stream converter.
module unicode_escape_to_utf8_core_test;
   import ue2u_pkg::*;

   localparam int RandomItems = 186;
   localparam int LongHoldCycles = 80;

   // One converted byte as it leaves the block
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_byte_type;

   // Receiver stall patterns
   typedef enum int {FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC} flow_mode_type;

   // Tracks escape state and the converted bytes still owed by the block
   class utf8_board;
      logic [7:0]    held [EscLen];
      int            held_n;
      logic [7:0]    step_bytes [$];
      text_byte_type expected_q [$];
      int            failures;

      function new();
         held_n   = 0;
         failures = 0;
         foreach (held[i]) held[i] = 8'h00;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Hex digit value, or -1 for anything else
      function int nibble_of(logic [7:0] c);
         if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
         if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + int'(HexAlphaOffset);
         if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + int'(HexAlphaOffset);
         return -1;
      endfunction

      // Held bytes can still grow into a complete escape
      function bit held_is_escape_start();
         for (int i = 0; i < held_n; i++) begin
            if (i == 0) begin
               if (held[i] != CharBackslash) return 1'b0;
            end else if (i == 1) begin
               if (held[i] != CharEscMark) return 1'b0;
            end else if (nibble_of(held[i]) < 0) begin
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void put_out(logic [7:0] b);
         if (step_bytes.size() < EscLen) step_bytes.push_back(b);
      endfunction

      function void release_first();
         for (int i = 1; i < held_n; i++) held[i - 1] = held[i];
         if (held_n > 0) held_n--;
      endfunction

      // Decode the four digits and encode the code point
      function void emit_code_point();
         logic [15:0] cp;
         cp = 16'h0000;
         for (int i = 2; i < EscLen; i++) cp = (cp << 4) | 16'(nibble_of(held[i]));
         if (cp < 16'h0080) begin
            put_out({1'b0, cp[6:0]});
         end else if (cp < 16'h0800) begin
            put_out(Utf8Lead2 | {3'b000, cp[10:6]});
            put_out(Utf8Cont | {2'b00, cp[5:0]});
         end else begin
            put_out(Utf8Lead3 | {4'b0000, cp[15:12]});
            put_out(Utf8Cont | {2'b00, cp[11:6]});
            put_out(Utf8Cont | {2'b00, cp[5:0]});
         end
         held_n = 0;
      endfunction

      // Advance the escape state by one accepted input item
      function void take_text_byte(logic [7:0] b, logic last);
         step_bytes.delete();
         if (held_n >= EscLen) held_n = 0;
         held[held_n] = b;
         held_n++;
         while (held_n > 0) begin
            if (!held_is_escape_start()) begin
               put_out(held[0]);
               release_first();
            end else if (held_n == EscLen) begin
               emit_code_point();
            end else begin
               break;
            end
         end
         // Flush a partial escape at the end of the text
         if (last) begin
            for (int i = 0; i < held_n; i++) put_out(held[i]);
            held_n = 0;
         end
         foreach (step_bytes[i]) begin
            expected_q.push_back('{data: step_bytes[i],
                                   last: last && (i == step_bytes.size() - 1)});
         end
      endfunction

      // Compare one output item with the oldest owed byte
      function void check_utf8_byte(logic [7:0] data, logic last);
         text_byte_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected output item: out_byte=%02h out_last=%0b", data, last);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (data !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, data);
            failures++;
         end
         if (last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   utf8_board     board = new();
   int            items_sent = 0;
   int            burst_left = 0;
   int            hold_requests = 0;
   int            holds_served = 0;
   int            hold_left = 0;
   int            pattern_cycle = 0;
   flow_mode_type stall_mode = FLOW_FREE;

   unicode_escape_to_utf8_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Hex digit character, letters in random case
   function automatic logic [7:0] digit_char(input logic [3:0] v);
      if (v < 4'd10) return CharZero + {4'h0, v};
      return ($urandom_range(0, 1) ? CharUpA : CharLowA) + {4'h0, v} - {4'h0, HexAlphaOffset};
   endfunction

   // Byte just outside the accepted digit ranges, a backslash or a random byte
   function automatic logic [7:0] near_miss();
      case ($urandom_range(0, 7))
         0:       return CharZero - 8'd1;
         1:       return CharNine + 8'd1;
         2:       return CharUpA - 8'd1;
         3:       return CharUpF + 8'd1;
         4:       return CharLowA - 8'd1;
         5:       return CharLowF + 8'd1;
         6:       return CharBackslash;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one item in bursts with random gaps, hold until accepted
   task automatic send_text_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.take_text_byte(b, last);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_escape(input logic [15:0] cp, input logic last);
      send_text_byte(CharBackslash, 1'b0);
      send_text_byte(CharEscMark, 1'b0);
      send_text_byte(digit_char(cp[15:12]), 1'b0);
      send_text_byte(digit_char(cp[11:8]), 1'b0);
      send_text_byte(digit_char(cp[7:4]), 1'b0);
      send_text_byte(digit_char(cp[3:0]), last);
   endtask

   // Stop offering and wait until every owed byte has come out
   task automatic wait_for_drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Receiver: long hold-off on request, otherwise a rotating stall pattern
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = LongHoldCycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         pattern_cycle++;
         if (pattern_cycle % 48 == 0) stall_mode = flow_mode_type'($urandom_range(0, 2));
         case (stall_mode)
            FLOW_FREE:     rsp_tready <= 1'b1;
            FLOW_RANDOM:   rsp_tready <= ($urandom_range(0, 9) < 6);
            FLOW_PERIODIC: rsp_tready <= (pattern_cycle % 4 != 3);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   // Check every accepted output item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_utf8_byte(rsp_tdata, rsp_tlast);
   end

   initial begin
      int          base;
      int          kind;
      int          cut;
      bit          ends_text;
      bit          paused;
      logic [7:0]  b;
      logic [15:0] cp;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      paused     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: code point zero, a surrogate, a broken escape followed by a
      // two-byte escape, an escape cut off by the end of text, plain extremes
      send_escape(16'h0000, 1'b0);
      send_escape(16'hD8AF, 1'b0);
      send_text_byte(CharBackslash, 1'b0);
      send_escape(16'h07FF, 1'b0);
      send_text_byte(CharBackslash, 1'b0);
      send_text_byte(CharEscMark, 1'b0);
      send_text_byte(digit_char(4'h1), 1'b1);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(8'h00, 1'b1);

      // Random: half escapes with random content, plus broken ones and noise
      base = items_sent;
      while (items_sent - base < RandomItems) begin
         if (hold_requests == 0 && items_sent - base >= 90) hold_requests++;
         if (!paused && items_sent - base >= 160) begin
            wait_for_drain();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            case ($urandom_range(0, 3))
               0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
               1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
               2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
               default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
            endcase
            send_escape(cp, $urandom_range(0, 11) == 0);
         end else if (kind < 7) begin
            cut       = $urandom_range(1, 5);
            ends_text = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < cut; i++) begin
               case (i)
                  0:       b = CharBackslash;
                  1:       b = CharEscMark;
                  default: b = digit_char(4'($urandom_range(0, 15)));
               endcase
               send_text_byte(b, ends_text && i == cut - 1);
            end
            if (!ends_text) send_text_byte(near_miss(), $urandom_range(0, 7) == 0);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
         end
      end

      wait_for_drain();
      req_tlast <= 1'b0;
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("[unicode_escape_to_utf8_core] OK");
      end else begin
         $display("[unicode_escape_to_utf8_core] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("[unicode_escape_to_utf8_core] ERROR");
      $finish;
   end

endmodule
